@@ design/i2e_pkg.sv @@
// Shared types, constants and tables of the ISO 8601 text to epoch milliseconds unit.
package i2e_pkg;

   localparam logic [2:0] STATUS_OK     = 3'd0;
   localparam logic [2:0] STATUS_LAYOUT = 3'd1;
   localparam logic [2:0] STATUS_DATE   = 3'd2;
   localparam logic [2:0] STATUS_TIME   = 3'd3;
   localparam logic [2:0] STATUS_RANGE  = 3'd4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   localparam logic [4:0] POS_LIMIT = 5'd19;

   localparam logic [6:0] MONTH_MAX  = 7'd12;
   localparam logic [6:0] HOUR_MAX   = 7'd23;
   localparam logic [6:0] MINUTE_MAX = 7'd59;
   localparam logic [6:0] SECOND_MAX = 7'd60;

   typedef struct packed {
      logic        neg;
      logic [13:0] mag;
   } year_type;

   typedef struct packed {
      logic       neg;
      logic [6:0] mag;
   } field_type;

   typedef struct packed {
      year_type  year;
      field_type month;
      field_type day;
      field_type hour;
      field_type minute;
      field_type second;
      logic      short_len;
      logic      full;
      logic      layout_err;
      logic      date_err;
      logic      time_err;
   } fields_type;

   typedef struct packed {
      logic mid_en;
      logic late_en;
      logic out_en;
   } stage_en_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // Day of the year at the start of each month, counted from the first of March.
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] r;
      unique case (m)
         4'd3:    r = 9'd0;
         4'd4:    r = 9'd31;
         4'd5:    r = 9'd61;
         4'd6:    r = 9'd92;
         4'd7:    r = 9'd122;
         4'd8:    r = 9'd153;
         4'd9:    r = 9'd184;
         4'd10:   r = 9'd214;
         4'd11:   r = 9'd245;
         4'd12:   r = 9'd275;
         4'd1:    r = 9'd306;
         4'd2:    r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m);
      logic [4:0] r;
      unique case (m)
         4'd2:    r = 5'd28;
         4'd4:    r = 5'd30;
         4'd6:    r = 5'd30;
         4'd9:    r = 5'd30;
         4'd11:   r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

@@ design/i2e_req_if.sv @@
// Handshake channel that carries one character word of the timestamp text.
interface i2e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

@@ design/i2e_rsp_if.sv @@
// Handshake channel that carries one result word: status and epoch milliseconds.
interface i2e_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        status;
   logic signed [48:0] epoch_millis;

   modport source (output valid, output status, output epoch_millis, input ready);
   modport sink   (input valid, input status, input epoch_millis, output ready);
endinterface

@@ design/i2e_scan.sv @@
// Character scanner that checks the layout and accumulates the date and time fields.
module i2e_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          character,
   input  logic                last_char,
   output i2e_pkg::fields_type scan_fields
);

   logic [4:0]          pos_ff;
   logic [4:0]          pos_in;
   i2e_pkg::fields_type fld_ff;
   i2e_pkg::fields_type fld_in;

   function automatic logic field_bad(input logic first, input logic [7:0] c);
      return !(i2e_pkg::is_digit(c) || (first && (c == i2e_pkg::CHAR_MINUS)));
   endfunction

   function automatic i2e_pkg::field_type feed_field(input i2e_pkg::field_type f,
                                                      input logic first,
                                                      input logic [7:0] c);
      i2e_pkg::field_type r;
      logic [6:0]         base;
      base  = first ? 7'd0 : f.mag;
      r.neg = first ? (c == i2e_pkg::CHAR_MINUS) : f.neg;
      r.mag = i2e_pkg::is_digit(c) ? 7'(base * 7'd10 + {3'b000, c[3:0]}) : base;
      return r;
   endfunction

   function automatic i2e_pkg::year_type feed_year(input i2e_pkg::year_type f,
                                                    input logic first,
                                                    input logic [7:0] c);
      i2e_pkg::year_type r;
      logic [13:0]       base;
      base  = first ? 14'd0 : f.mag;
      r.neg = first ? (c == i2e_pkg::CHAR_MINUS) : f.neg;
      r.mag = i2e_pkg::is_digit(c) ? 14'(base * 14'd10 + {10'd0, c[3:0]}) : base;
      return r;
   endfunction

   always_comb begin
      fld_in           = fld_ff;
      fld_in.short_len = (pos_ff < 5'd9);
      fld_in.full      = (pos_ff >= 5'd18);
      case (pos_ff) inside
         [5'd0:5'd3]: begin
            fld_in.year     = feed_year(fld_ff.year, pos_ff == 5'd0, character);
            fld_in.date_err = fld_ff.date_err | field_bad(pos_ff == 5'd0, character);
         end
         5'd4, 5'd7: begin
            fld_in.layout_err = fld_ff.layout_err | (character != i2e_pkg::CHAR_MINUS);
         end
         5'd5, 5'd6: begin
            fld_in.month    = feed_field(fld_ff.month, pos_ff == 5'd5, character);
            fld_in.date_err = fld_ff.date_err | field_bad(pos_ff == 5'd5, character);
         end
         5'd8, 5'd9: begin
            fld_in.day      = feed_field(fld_ff.day, pos_ff == 5'd8, character);
            fld_in.date_err = fld_ff.date_err | field_bad(pos_ff == 5'd8, character);
         end
         5'd10: begin
            fld_in.time_err = fld_ff.time_err | ((character != i2e_pkg::CHAR_SPACE) &&
                                                 (character != i2e_pkg::CHAR_T));
         end
         5'd11, 5'd12: begin
            fld_in.hour     = feed_field(fld_ff.hour, pos_ff == 5'd11, character);
            fld_in.time_err = fld_ff.time_err | field_bad(pos_ff == 5'd11, character);
         end
         5'd13, 5'd16: begin
            fld_in.time_err = fld_ff.time_err | (character != i2e_pkg::CHAR_COLON);
         end
         5'd14, 5'd15: begin
            fld_in.minute   = feed_field(fld_ff.minute, pos_ff == 5'd14, character);
            fld_in.time_err = fld_ff.time_err | field_bad(pos_ff == 5'd14, character);
         end
         5'd17, 5'd18: begin
            fld_in.second   = feed_field(fld_ff.second, pos_ff == 5'd17, character);
            fld_in.time_err = fld_ff.time_err | field_bad(pos_ff == 5'd17, character);
         end
         default: begin
         end
      endcase
   end

   assign pos_in      = (pos_ff < i2e_pkg::POS_LIMIT) ? 5'(pos_ff + 5'd1) : pos_ff;
   assign scan_fields = fld_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         fld_ff <= '0;
      end else if (accept) begin
         if (last_char) begin
            pos_ff <= '0;
            fld_ff <= '0;
         end else begin
            pos_ff <= pos_in;
            fld_ff <= fld_in;
         end
      end
   end

endmodule

@@ design/i2e_calc.sv @@
// Result pipeline: range checks, civil date to day count, and scaling to milliseconds.
module i2e_calc (
   input  logic                  clock,
   input  i2e_pkg::fields_type   fields,
   input  i2e_pkg::stage_en_type stage_en,
   output logic [2:0]            status,
   output logic signed [48:0]    epoch_millis
);

   // Floor of a value below 16384 divided by 100, as a quarter divided by 25.
   function automatic logic [7:0] div100(input logic [13:0] v);
      logic [24:0] p;
      p = 25'(v[13:2]) * 25'd5243;
      return p[24:17];
   endfunction

   logic signed [14:0] year_val;
   logic [13:0]        yl_in;
   logic [13:0]        ys_in;
   logic [2:0]         st_mid_in;
   logic               rbad_in;
   logic [6:0]         hour_in;
   logic [6:0]         minute_in;
   logic [6:0]         second_in;
   logic [16:0]        sod_in;
   logic [8:0]         doy_in;

   logic [2:0]  st_mid_ff;
   logic        rbad_ff;
   logic [13:0] yl_ff;
   logic [13:0] ys_ff;
   logic [7:0]  cl_ff;
   logic [7:0]  cs_ff;
   logic [16:0] sod_mid_ff;
   logic [8:0]  doy_ff;
   logic [3:0]  mon_ff;
   logic [6:0]  day_ff;

   logic               leap;
   logic [4:0]         mlen;
   logic [2:0]         st_late_in;
   logic [23:0]        days_pos;
   logic [23:0]        days_neg;
   logic signed [22:0] days_in;

   logic [2:0]         st_late_ff;
   logic signed [22:0] days_ff;
   logic [16:0]        sod_late_ff;

   logic [48:0] days_ext;
   logic [48:0] millis_in;

   always_comb begin
      year_val  = fields.year.neg ? -$signed({1'b0, fields.year.mag})
                                  :  $signed({1'b0, fields.year.mag});
      yl_in     = 14'(year_val + 15'sd1200);
      ys_in     = yl_in - {13'd0, (fields.month.mag <= 7'd2)};
      hour_in   = fields.full ? fields.hour.mag : 7'd0;
      minute_in = fields.full ? fields.minute.mag : 7'd0;
      second_in = fields.full ? fields.second.mag : 7'd0;
      sod_in    = 17'(hour_in) * 17'd3600 + 17'(minute_in) * 17'd60 + 17'(second_in);
      doy_in    = i2e_pkg::month_offset(fields.month.mag[3:0]) + 9'(fields.day.mag) - 9'd1;

      if (fields.short_len || fields.layout_err) begin
         st_mid_in = i2e_pkg::STATUS_LAYOUT;
      end else if (fields.date_err) begin
         st_mid_in = i2e_pkg::STATUS_DATE;
      end else if (fields.full && fields.time_err) begin
         st_mid_in = i2e_pkg::STATUS_TIME;
      end else begin
         st_mid_in = i2e_pkg::STATUS_OK;
      end

      rbad_in = fields.month.neg || (fields.month.mag == 7'd0) ||
                (fields.month.mag > i2e_pkg::MONTH_MAX) ||
                fields.day.neg || (fields.day.mag == 7'd0) ||
                (fields.full && ((fields.hour.neg && (fields.hour.mag != 7'd0)) ||
                                 (fields.hour.mag > i2e_pkg::HOUR_MAX) ||
                                 (fields.minute.neg && (fields.minute.mag != 7'd0)) ||
                                 (fields.minute.mag > i2e_pkg::MINUTE_MAX) ||
                                 (fields.second.neg && (fields.second.mag != 7'd0)) ||
                                 (fields.second.mag > i2e_pkg::SECOND_MAX)));
   end

   always_ff @(posedge clock) begin
      if (stage_en.mid_en) begin
         st_mid_ff  <= st_mid_in;
         rbad_ff    <= rbad_in;
         yl_ff      <= yl_in;
         ys_ff      <= ys_in;
         cl_ff      <= div100(yl_in);
         cs_ff      <= div100(ys_in);
         sod_mid_ff <= sod_in;
         doy_ff     <= doy_in;
         mon_ff     <= fields.month.mag[3:0];
         day_ff     <= fields.day.mag;
      end
   end

   // The year is offset by 1200, a whole number of 400-year cycles, to keep years above -1200 positive.
   always_comb begin
      leap = (yl_ff[1:0] == 2'b00) &&
             ((yl_ff != 14'(14'(cl_ff) * 14'd100)) || (cl_ff[1:0] == 2'b00));
      mlen = ((mon_ff == 4'd2) && leap) ? 5'd29 : i2e_pkg::month_days(mon_ff);

      if (st_mid_ff != i2e_pkg::STATUS_OK) begin
         st_late_in = st_mid_ff;
      end else if (rbad_ff || (day_ff > {2'b00, mlen})) begin
         st_late_in = i2e_pkg::STATUS_RANGE;
      end else begin
         st_late_in = i2e_pkg::STATUS_OK;
      end

      days_pos = 24'(ys_ff) * 24'd365 + 24'(ys_ff[13:2]) + 24'(cs_ff[7:2]) + 24'(doy_ff);
      days_neg = 24'(cs_ff) + 24'd1157759;
      days_in  = $signed(23'(days_pos - days_neg));
   end

   always_ff @(posedge clock) begin
      if (stage_en.late_en) begin
         st_late_ff  <= st_late_in;
         days_ff     <= days_in;
         sod_late_ff <= sod_mid_ff;
      end
   end

   assign days_ext  = 49'(days_ff);
   assign millis_in = days_ext * 49'd86400000 + 49'(sod_late_ff) * 49'd1000;

   always_ff @(posedge clock) begin
      if (stage_en.out_en) begin
         status       <= st_late_ff;
         epoch_millis <= (st_late_ff == i2e_pkg::STATUS_OK) ? $signed(millis_in) : '0;
      end
   end

endmodule

@@ design/iso8601_text_to_epoch_millis_unit.sv @@
// Top level: ISO 8601 timestamp text, one character word per cycle, to Unix milliseconds.
// Accepts one character word per cycle unless a stalled result holds the input. Once the
// last_char word is accepted, the fields pass a four-stage pipeline: the scan register,
// two calculation stages and the output register, which presents the result word; results
// can follow one per cycle when taken, a stalled result holds only the stages behind it,
// and bubbles are filled. Synchronous reset clears the character position, the field
// accumulators and all stage valid flags; the result payload registers are not reset.
module iso8601_text_to_epoch_millis_unit (
   input  logic      clock,
   input  logic      reset,
   i2e_req_if.sink   req,
   i2e_rsp_if.source rsp
);

   logic                  accept;
   logic                  accept_last;
   i2e_pkg::fields_type   scan_fields;
   i2e_pkg::fields_type   p1_ff;
   i2e_pkg::stage_en_type stage_en;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic adv1, adv2, adv3, adv4;

   assign adv4 = !v4_ff || rsp.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req.ready   = adv1;
   assign accept      = req.valid && adv1;
   assign accept_last = accept && req.last_char;

   assign v1_in = accept_last || (v1_ff && !adv2);
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? v3_ff : v4_ff;

   assign stage_en.mid_en  = adv2;
   assign stage_en.late_en = adv3;
   assign stage_en.out_en  = adv4;

   i2e_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .character   (req.character),
      .last_char   (req.last_char),
      .scan_fields (scan_fields)
   );

   always_ff @(posedge clock) begin
      if (accept_last) begin
         p1_ff <= scan_fields;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   i2e_calc u_calc (
      .clock        (clock),
      .fields       (p1_ff),
      .stage_en     (stage_en),
      .status       (rsp.status),
      .epoch_millis (rsp.epoch_millis)
   );

   assign rsp.valid = v4_ff;

endmodule

@@ design/i2e_checker.sv @@
// Port-level checker for the timestamp unit, bound to the top level.
module i2e_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [2:0]        rsp_status,
   input logic signed [48:0] rsp_epoch_millis
);

   // A result word that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_epoch_millis))
      else $error("result word changed while stalled");

   // A failed parse always reports zero milliseconds.
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != i2e_pkg::STATUS_OK) |-> rsp_epoch_millis == '0)
      else $error("nonzero milliseconds with an error status");

   // Only the five defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == i2e_pkg::STATUS_OK) ||
                    (rsp_status == i2e_pkg::STATUS_LAYOUT) ||
                    (rsp_status == i2e_pkg::STATUS_DATE) ||
                    (rsp_status == i2e_pkg::STATUS_TIME) ||
                    (rsp_status == i2e_pkg::STATUS_RANGE))
      else $error("undefined status code");

   // The input side is only held back when a result word is stalled at the output.
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input not ready without an output stall");

   // No result word straight after reset.
   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word presented straight after reset");

endmodule

bind iso8601_text_to_epoch_millis_unit i2e_checker u_i2e_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_epoch_millis (rsp.epoch_millis)
);
